>>> hw/rtl/rmwq_pkg.sv
package rmwq_pkg;

  // Fixed widths of the request and result fields on the stream ports.
  localparam int IdW    = 8;
  localparam int DepthW = 16;

  // Request kinds carried in tuser.
  localparam logic KindAcquire = 1'b0;
  localparam logic KindRelease = 1'b1;

  // Error codes reported with every result.
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FREE = 2'd1,
    ERR_FULL = 2'd2,
    ERR_SAT  = 2'd3
  } err_e;

  // One lock request as held in the input register.
  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] thread_id;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    err_e              error;
    logic [DepthW-1:0] nest_depth;
    logic [IdW-1:0]    woken_thread;
    logic              woken_valid;
    logic              must_wait;
    logic              granted;
  } res_t;

endpackage

>>> hw/rtl/recursive_mutex_wait_queue.sv
// Lock manager for one recursive mutex with a first-come, first-served queue
// of waiting threads. Each request on the slave stream is an acquire or a
// release (tuser) for a thread id (tdata); each produces exactly one result on
// the master stream. One request is taken every clock cycle when the result
// side keeps up. The lock decision is made combinationally from the request
// register and stored in the result register when the request advances, and
// the result is offered from there. The waiter queue is a small RAM whose next
// head entry is fetched ahead from a registered read port, so a handoff on
// release does not wait for a RAM read. A stalled result register still
// lets one further request wait in the request register.
module recursive_mutex_wait_queue
  import rmwq_pkg::*;
#(
  parameter int WAIT_DEPTH  = 16,
  parameter int THREAD_BITS = 8,
  parameter int NEST_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] thread_id
  input  logic        s_axis_tuser,  // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [0] granted, [1] must_wait, [2] woken_valid,
                                     // [10:3] woken_thread, [26:11] nest_depth,
                                     // [28:27] error, [31:29] zero
);

  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  res_t res_q;
  res_t res_d;
  logic advance;

  // The request register moves on when the result register is free or is
  // being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  rmwq_core #(
    .WAIT_DEPTH  (WAIT_DEPTH),
    .THREAD_BITS (THREAD_BITS),
    .NEST_BITS   (NEST_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (advance),
    .req_i       (req_q),
    .res_o       (res_d)
  );

  // Valid flags of the request and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q.kind      <= s_axis_tuser;
      req_q.thread_id <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.error, res_q.nest_depth, res_q.woken_thread,
                          res_q.woken_valid, res_q.must_wait, res_q.granted};

`ifndef SYNTHESIS
  // A queued or refused acquire leaves the lock held by someone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.must_wait || res_q.error == ERR_FULL) |-> res_q.nest_depth != '0)
    else $error("waiting acquire reported with a free lock");

  // A handoff always starts the new owner at a single hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.woken_valid |-> res_q.nest_depth == DepthW'(1) && !res_q.granted)
    else $error("handoff with wrong nesting depth");

  // A release of a free lock changes nothing and leaves the lock free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.error == ERR_FREE |->
      res_q.nest_depth == '0 && !res_q.woken_valid && !res_q.granted)
    else $error("release of free lock had an effect");

  // A granted acquire always reports a held lock.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.granted |-> res_q.nest_depth != '0 && !res_q.must_wait)
    else $error("grant without a held lock");
`endif

endmodule

>>> hw/rtl/rmwq_ram.sv
module rmwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rmwq_core.sv
module rmwq_core
  import rmwq_pkg::*;
#(
  parameter int WAIT_DEPTH  = 16,
  parameter int THREAD_BITS = 8,
  parameter int NEST_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output res_t res_o
);

  // Stored id width: only the low bits of the 8-bit field are significant.
  localparam int TW = (THREAD_BITS < IdW) ? THREAD_BITS : IdW;
  localparam int PW = $clog2(WAIT_DEPTH);
  localparam int FW = $clog2(WAIT_DEPTH + 1);

  logic                 held_q, held_d;
  logic [TW-1:0]        owner_q, owner_d;
  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic [PW-1:0]        head_q, head_d;
  logic [PW-1:0]        tail_q, tail_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic                 byp_q, byp_d;
  logic [TW-1:0]        byp_data_q;

  logic [TW-1:0] tid;
  logic [TW-1:0] ram_rdata;
  logic [TW-1:0] head_tid;
  logic          push;
  logic          granted, must_wait, woken_valid;
  err_e          error;

  assign tid = req_i.thread_id[TW-1:0];

  // Waiter queue storage; the read port always fetches the next head entry.
  rmwq_ram #(
    .WIDTH (TW),
    .DEPTH (WAIT_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail_q),
    .wdata_i (tid),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // A waiter written to the head slot in the previous cycle is not yet
  // visible at the read port, so it is taken from the bypass register.
  assign head_tid = byp_q ? byp_data_q : ram_rdata;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(WAIT_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Lock decision for the request in the input register.
  always_comb begin
    held_d      = held_q;
    owner_d     = owner_q;
    nest_d      = nest_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    push        = 1'b0;
    granted     = 1'b0;
    must_wait   = 1'b0;
    woken_valid = 1'b0;
    error       = ERR_NONE;
    if (req_valid_i) begin
      if (req_i.kind == KindAcquire) begin
        if (held_q && owner_q == tid) begin
          granted = 1'b1;
          if (nest_q == {NEST_BITS{1'b1}}) begin
            error = ERR_SAT;
          end else begin
            nest_d = nest_q + NEST_BITS'(1);
          end
        end else if (!held_q) begin
          held_d  = 1'b1;
          owner_d = tid;
          nest_d  = NEST_BITS'(1);
          granted = 1'b1;
        end else if (fill_q == FW'(WAIT_DEPTH)) begin
          error = ERR_FULL;
        end else begin
          push      = 1'b1;
          tail_d    = next_slot(tail_q);
          fill_d    = fill_q + FW'(1);
          must_wait = 1'b1;
        end
      end else begin
        if (!held_q) begin
          error = ERR_FREE;
        end else if (nest_q > NEST_BITS'(1)) begin
          nest_d = nest_q - NEST_BITS'(1);
        end else if (fill_q != '0) begin
          // Direct handoff to the oldest waiter.
          head_d      = next_slot(head_q);
          fill_d      = fill_q - FW'(1);
          owner_d     = head_tid;
          nest_d      = NEST_BITS'(1);
          woken_valid = 1'b1;
        end else begin
          held_d  = 1'b0;
          owner_d = '0;
          nest_d  = '0;
        end
      end
    end
  end

  assign byp_d = push && (tail_q == head_d);

  // Result fields.
  always_comb begin
    res_o.granted      = granted;
    res_o.must_wait    = must_wait;
    res_o.woken_valid  = woken_valid;
    res_o.woken_thread = woken_valid ? IdW'(owner_d) : '0;
    res_o.nest_depth   = held_d ? DepthW'(nest_d) : '0;
    res_o.error        = error;
  end

  // Lock and queue state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      owner_q <= '0;
      nest_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      byp_q   <= 1'b0;
    end else begin
      held_q  <= held_d;
      owner_q <= owner_d;
      nest_q  <= nest_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      byp_q   <= byp_d;
    end
  end

  // Bypass data needs no reset; it is only used while the bypass flag is set.
  always_ff @(posedge clk_i) begin
    if (byp_d) begin
      byp_data_q <= tid;
    end
  end

endmodule

>>> bench/recursive_mutex_wait_queue_tb.sv
`timescale 1ns / 1ps

module recursive_mutex_wait_queue_tb;
  import rmwq_pkg::*;

  localparam int          WaitDepth  = 16;
  localparam logic [15:0] NestMax    = 16'hFFFF;
  localparam int          HoldCycles = 300;
  localparam int          StallLimit = 2000;

  // Tracks the lock as the block should see it and holds the results still to come.
  class lock_checker;
    bit                held;
    logic [IdW-1:0]    owner;
    logic [DepthW-1:0] depth;
    logic [IdW-1:0]    waiters[$];
    res_t              outcome_q[$];
    int unsigned       mismatches;

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // Works out the result of an accepted request and moves the lock state on.
    function void note_request(logic kind, logic [IdW-1:0] tid);
      res_t r;
      r = '0;
      r.error = ERR_NONE;
      if (kind == KindAcquire) begin
        if (held && owner == tid) begin
          r.granted = 1'b1;
          if (depth == NestMax) begin
            r.error = ERR_SAT;
          end else begin
            depth++;
          end
        end else if (!held) begin
          held      = 1'b1;
          owner     = tid;
          depth     = DepthW'(1);
          r.granted = 1'b1;
        end else if (waiters.size() >= WaitDepth) begin
          r.error = ERR_FULL;
        end else begin
          waiters.push_back(tid);
          r.must_wait = 1'b1;
        end
      end else begin
        // The caller of a release is not checked; it always acts on the owner's count.
        if (!held) begin
          r.error = ERR_FREE;
        end else if (depth > 1) begin
          depth--;
        end else if (waiters.size() > 0) begin
          owner          = waiters.pop_front();
          depth          = DepthW'(1);
          r.woken_valid  = 1'b1;
          r.woken_thread = owner;
        end else begin
          held  = 1'b0;
          owner = '0;
          depth = '0;
        end
      end
      r.nest_depth = held ? depth : '0;
      outcome_q.push_back(r);
    endfunction

    function void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
        mismatches++;
      end
    endfunction

    // Compares one delivered result with the oldest outstanding one.
    function void check_result(logic [31:0] data);
      res_t want;
      res_t got;
      if (outcome_q.size() == 0) begin
        $display("%0t ns: result expected none, got %h", $time, data);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      got  = res_t'(data[28:0]);
      compare_field("granted", want.granted, got.granted);
      compare_field("must_wait", want.must_wait, got.must_wait);
      compare_field("woken_valid", want.woken_valid, got.woken_valid);
      compare_field("woken_thread", want.woken_thread, got.woken_thread);
      compare_field("nest_depth", want.nest_depth, got.nest_depth);
      compare_field("error", int'(want.error), int'(got.error));
      compare_field("padding", 0, data[31:29]);
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni        = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata  = '0;  // [7:0] thread_id
  logic           s_axis_tuser  = 1'b0; // [0] kind
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [31:0]    m_axis_tdata;  // [0] granted, [1] must_wait, [2] woken_valid,
                                 // [10:3] woken_thread, [26:11] nest_depth,
                                 // [28:27] error, [31:29] zero

  lock_checker board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_kick     = 1'b0;
  int unsigned quiet_cycles  = 0;

  recursive_mutex_wait_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is kicked.
  initial begin
    bit          seen_kick;
    int unsigned hold_left;
    seen_kick = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_kick != seen_kick) begin
        seen_kick = hold_kick;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every delivered result is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata);
    end
  end

  // Ends the run if neither side moves a request or a result for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, with random gaps first, and returns at the falling edge
  // after it has been taken.
  task automatic send_request(input logic kind, input logic [IdW-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tid;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(kind, tid);
    @(negedge clk_i);
  endtask

  // Mostly a small crew of threads contending for the lock, with some stray ids.
  task automatic send_random_burst(input int unsigned count);
    logic [IdW-1:0] crew[4];
    logic           kind;
    logic [IdW-1:0] tid;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) begin
        foreach (crew[k]) crew[k] = IdW'($urandom_range(255));
      end
      kind = ($urandom_range(99) < 55) ? KindAcquire : KindRelease;
      tid  = ($urandom_range(99) < 85) ? crew[$urandom_range(3)] : IdW'($urandom_range(255));
      send_request(kind, tid);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 23;
    recv_idle_pct = 79;

    // Release of a free lock, then nesting and a release by a thread that is not the owner.
    send_request(KindRelease, 8'h00);
    send_request(KindAcquire, 8'hFF);
    send_request(KindAcquire, 8'hFF);
    send_request(KindRelease, 8'h00);
    // Fill the waiter queue, one thread queued twice, then overflow it.
    for (int i = 1; i < WaitDepth; i++) send_request(KindAcquire, IdW'(i));
    send_request(KindAcquire, 8'h01);
    send_request(KindAcquire, 8'hAA);
    // Last releases hand the lock straight to the oldest waiters.
    send_request(KindRelease, 8'hFF);
    send_request(KindRelease, 8'h55);

    send_random_burst(470);

    send_idle_pct = 79;
    recv_idle_pct = 23;
    send_random_burst(470);

    // No idling; the result side stalls for a long stretch so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_kick = ~hold_kick;
    send_random_burst(460);

    // Free the lock, then nest one owner 21 levels deep with a waiter behind it
    // and unwind until the waiter takes over.
    while (board.held) send_request(KindRelease, 8'h00);
    send_request(KindAcquire, 8'hC3);
    send_request(KindAcquire, 8'h3C);
    for (int i = 0; i < 20; i++) send_request(KindAcquire, 8'hC3);
    for (int i = 0; i < 21; i++) send_request(KindRelease, 8'hC3);
    send_request(KindRelease, 8'h3C);
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
